>>> rtl/lrcm_pkg.sv
// Shared types and constants for the learned remote code matcher.
package lrcm_pkg;

  localparam int CODE_W = 24;
  localparam int ADDR_W = 20;
  localparam int NIB_W  = 4;
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;
  localparam int ID_W   = 9;

  localparam logic [OP_W-1:0] OP_MATCH = 2'd0;
  localparam logic [OP_W-1:0] OP_LEARN = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_NOMATCH = 3'd0;
  localparam logic [ST_W-1:0] ST_MATCHED = 3'd1;
  localparam logic [ST_W-1:0] ST_LEARNED = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_CLEARED = 3'd4;

  localparam logic [NIB_W-1:0] CMD_OUT1_ON  = 4'b0001;
  localparam logic [NIB_W-1:0] CMD_OUT1_OFF = 4'b0010;
  localparam logic [NIB_W-1:0] CMD_OUT2_ON  = 4'b0100;
  localparam logic [NIB_W-1:0] CMD_OUT2_OFF = 4'b1000;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] entry_id;
    logic            out1_on;
    logic            out2_on;
    logic [ID_W-1:0] entry_count;
  } lrcm_res_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_DONE = 3'b100
  } lrcm_state_t;

endpackage

>>> rtl/learned_remote_code_matcher.sv
// Top level of the learned remote code matcher: stream ports and result register.
// Learned remote code matcher. Each request carries an operation in in_tuser
// (match, learn, clear) and a 24-bit code in in_tdata whose bits 23..4 are the
// remote address and bits 3..0 the command nibble. Learn appends the address
// to a table of TABLE_DEPTH entries (status "table full" once it is used up),
// clear empties the table, and match scans the used entries from the first
// and takes the first equal address, applying the command nibble to the two
// output states (0001/0010 switch output 1 on/off, 0100/1000 output 2). Every
// request yields exactly one result. Learn, clear and unused operations need no
// search; a match reads the used entries in order and stops early on a hit,
// through the single read port of the table, which delivers one entry per
// cycle to the shared comparator. in_tready is high only while the sequencer
// is idle, but a new request is taken while the last result still waits in
// the output register. The table needs no clearing pass after reset: only
// entries below the fill count are ever compared.
module learned_remote_code_matcher #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] code
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] status, [11:3] entry_id, [12] out1_on,
                                  // [13] out2_on, [22:14] entry_count, [23] zero
);
  import lrcm_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [ADDR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  lrcm_res_t         res;
  logic              out_valid_r, out_valid_nxt;
  lrcm_res_t         out_res_r,   out_res_nxt;

  lrcm_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_code   (in_tdata),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  lrcm_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk       (clk),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Load the output register when it is empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds without reset.
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.entry_count, out_res_r.out2_on, out_res_r.out1_on,
                       out_res_r.entry_id, out_res_r.status};

endmodule

>>> rtl/lrcm_table.sv
// Learned address table: single-port memory with registered read data.
module lrcm_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int IDX_W       = 8
) (
  input  logic                       clk,
  input  logic                       mem_we,
  input  logic [IDX_W-1:0]           mem_addr,
  input  logic [lrcm_pkg::ADDR_W-1:0] mem_wdata,
  output logic [lrcm_pkg::ADDR_W-1:0] mem_rdata
);
  import lrcm_pkg::*;

  logic [ADDR_W-1:0] mem_r [TABLE_DEPTH];
  logic [ADDR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end else begin
      rdata_r <= mem_r[mem_addr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

>>> rtl/lrcm_ctrl.sv
// Sequencer: operation decode, entry count, linear search and output states.
module lrcm_ctrl #(
  parameter int TABLE_DEPTH = 256,
  parameter int IDX_W       = 8,
  parameter int CNT_W       = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lrcm_pkg::OP_W-1:0]    in_op,
  input  logic [lrcm_pkg::CODE_W-1:0]  in_code,
  output logic                         mem_we,
  output logic [IDX_W-1:0]             mem_addr,
  output logic [lrcm_pkg::ADDR_W-1:0]  mem_wdata,
  input  logic [lrcm_pkg::ADDR_W-1:0]  mem_rdata,
  output logic                         res_valid,
  input  logic                         res_ready,
  output lrcm_pkg::lrcm_res_t          res
);
  import lrcm_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  lrcm_state_t       state_r,   state_nxt;
  logic [CNT_W-1:0]  count_r,   count_nxt;
  logic [CNT_W-1:0]  rd_idx_r,  rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [ADDR_W-1:0] addr_r,    addr_nxt;
  logic [NIB_W-1:0]  nib_r,     nib_nxt;
  logic              out1_r,    out1_nxt;
  logic              out2_r,    out2_nxt;
  lrcm_res_t         res_r,     res_nxt;
  logic              hit;
  logic              new_out1;
  logic              new_out2;

  assign hit = cmp_vld_r && (mem_rdata == addr_r);

  // Command nibble applied on a hit.
  always_comb begin
    new_out1 = out1_r;
    new_out2 = out2_r;
    unique case (nib_r)
      CMD_OUT1_ON:  new_out1 = 1'b1;
      CMD_OUT1_OFF: new_out1 = 1'b0;
      CMD_OUT2_ON:  new_out2 = 1'b1;
      CMD_OUT2_OFF: new_out2 = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    addr_nxt    = addr_r;
    nib_nxt     = nib_r;
    out1_nxt    = out1_r;
    out2_nxt    = out2_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_addr    = rd_idx_r[IDX_W-1:0];
    mem_wdata   = in_code[CODE_W-1:NIB_W];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_nxt            = in_code[CODE_W-1:NIB_W];
          nib_nxt             = in_code[NIB_W-1:0];
          res_nxt.status      = ST_NOMATCH;
          res_nxt.entry_id    = '0;
          res_nxt.out1_on     = out1_r;
          res_nxt.out2_on     = out2_r;
          res_nxt.entry_count = ID_W'(count_r);
          state_nxt           = S_DONE;
          unique case (in_op)
            OP_MATCH: begin
              if (count_r != '0) begin
                rd_idx_nxt  = '0;
                cmp_vld_nxt = 1'b0;
                state_nxt   = S_SRCH;
              end
            end
            OP_LEARN: begin
              if (count_r < DEPTH_C) begin
                mem_we              = 1'b1;
                mem_addr            = count_r[IDX_W-1:0];
                count_nxt           = count_r + ONE_C;
                res_nxt.status      = ST_LEARNED;
                res_nxt.entry_id    = ID_W'(count_r + ONE_C);
                res_nxt.entry_count = ID_W'(count_r + ONE_C);
              end else begin
                res_nxt.status = ST_FULL;
              end
            end
            OP_CLEAR: begin
              count_nxt           = '0;
              res_nxt.status      = ST_CLEARED;
              res_nxt.entry_count = '0;
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        // Read one entry and compare the previous one each cycle.
        if (hit) begin
          out1_nxt         = new_out1;
          out2_nxt         = new_out2;
          res_nxt.status   = ST_MATCHED;
          res_nxt.entry_id = ID_W'(CNT_W'(cmp_idx_r) + ONE_C);
          res_nxt.out1_on  = new_out1;
          res_nxt.out2_on  = new_out2;
          state_nxt        = S_DONE;
        end else if (rd_idx_r != count_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + ONE_C;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      out1_r    <= 1'b0;
      out2_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out1_r    <= out1_nxt;
      out2_r    <= out2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    addr_r    <= addr_nxt;
    nib_r     <= nib_nxt;
    res_r     <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

>>> dv/testbench.sv
// Self-checking stream testbench for the learned remote code matcher.
`timescale 1ns / 100ps

module testbench;
  import lrcm_pkg::*;

  localparam int TABLE_DEPTH = 256;
  // The operation field allows a fourth code that the block must ignore.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_REQUESTS = 530;

  // Predicts each result from its own copy of the table and output states,
  // and queues the results still owed by the block.
  class matcher_scoreboard;
    logic [ADDR_W-1:0] addr_table [TABLE_DEPTH];
    int                used;
    logic              out1;
    logic              out2;
    lrcm_res_t         pending_results[$];
    int                fail_count;
    int                full_hits;
    int                peak_fill;
    int                status_tally [5];

    function new();
      foreach (addr_table[i]) addr_table[i] = '0;
      used = 0;
      out1 = 1'b0;
      out2 = 1'b0;
      fail_count = 0;
      full_hits = 0;
      peak_fill = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function lrcm_res_t predict_step(logic [OP_W-1:0] op, logic [CODE_W-1:0] code);
      lrcm_res_t         res;
      logic [ADDR_W-1:0] addr;
      res = '0;
      addr = code[CODE_W-1:NIB_W];
      case (op)
        OP_MATCH: begin
          // First equal address wins, so duplicates resolve to the oldest entry.
          for (int i = 0; i < used; i++) begin
            if (addr_table[i] == addr) begin
              res.status = ST_MATCHED;
              res.entry_id = ID_W'(i + 1);
              case (code[NIB_W-1:0])
                CMD_OUT1_ON:  out1 = 1'b1;
                CMD_OUT1_OFF: out1 = 1'b0;
                CMD_OUT2_ON:  out2 = 1'b1;
                CMD_OUT2_OFF: out2 = 1'b0;
                default: ;
              endcase
              break;
            end
          end
        end
        OP_LEARN: begin
          if (used < TABLE_DEPTH) begin
            addr_table[used] = addr;
            used++;
            res.status = ST_LEARNED;
            res.entry_id = ID_W'(used);
          end else begin
            res.status = ST_FULL;
          end
        end
        OP_CLEAR: begin
          foreach (addr_table[i]) addr_table[i] = '0;
          used = 0;
          res.status = ST_CLEARED;
        end
        default: ;
      endcase
      res.out1_on = out1;
      res.out2_on = out2;
      res.entry_count = ID_W'(used);
      return res;
    endfunction

    function void log_request(logic [OP_W-1:0] op, logic [CODE_W-1:0] code);
      lrcm_res_t res;
      res = predict_step(op, code);
      pending_results.push_back(res);
      if (res.status == ST_FULL) full_hits++;
      if (op != OP_UNUSED) status_tally[res.status]++;
      if (used > peak_fill) peak_fill = used;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(logic [23:0] data);
      lrcm_res_t want;
      if (pending_results.size() == 0) begin
        $error("result 0x%06h arrived with no request outstanding", data);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status", want.status, data[2:0]);
      check_field("entry_id", want.entry_id, data[11:3]);
      check_field("out1_on", want.out1_on, data[12]);
      check_field("out2_on", want.out2_on, data[13]);
      check_field("entry_count", want.entry_count, data[22:14]);
      check_field("pad", 0, data[23]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [23:0] code
  logic [1:0]  in_tuser   = '0;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [2:0] status, [11:3] entry_id, [12] out1_on,
                                  // [13] out2_on, [22:14] entry_count, [23] zero

  matcher_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int clear_base    = 0;
  int fill_goal     = 0;
  bit fill_mode     = 1'b0;
  int requests_sent = 0;

  learned_remote_code_matcher #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset from the start, then release it for good.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stall the result channel at the rate the current phase asks for.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Sample both handshakes at the edge: check a delivered result against the
  // oldest prediction, and predict the result of every accepted request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.log_request(in_tuser, in_tdata);
    end
  end

  // Offer one request, idling first at random, and hold it until accepted.
  task automatic push_request(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Build one random request. Most matches and many learns reuse addresses
  // already in the table so hits, duplicates and command nibbles get exercised.
  task automatic random_request();
    int                pick;
    int                clear_pct;
    int                learn_pct;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [NIB_W-1:0]  nib;
    // While filling, hold off clears until the full table has been hit a few times.
    clear_pct = fill_mode ? ((sb.full_hits < fill_goal) ? 0 : 5) : clear_base;
    learn_pct = fill_mode ? 60 : 40;
    pick = $urandom_range(0, 99);
    addr = ADDR_W'($urandom);
    nib  = NIB_W'($urandom_range(0, 15));
    if (pick < clear_pct) begin
      op = OP_CLEAR;
    end else if (pick < clear_pct + 3) begin
      op = OP_UNUSED;
    end else if (pick < clear_pct + 3 + learn_pct) begin
      op = OP_LEARN;
      case ($urandom_range(0, 9))
        0: addr = '0;
        1: addr = '1;
        2, 3, 4: begin
          if (sb.used > 0) addr = sb.addr_table[$urandom_range(0, sb.used - 1)];
        end
        default: ;
      endcase
    end else begin
      op = OP_MATCH;
      if (sb.used > 0 && $urandom_range(0, 3) != 0)
        addr = sb.addr_table[$urandom_range(0, sb.used - 1)];
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 3))
          0: nib = CMD_OUT1_ON;
          1: nib = CMD_OUT1_OFF;
          2: nib = CMD_OUT2_ON;
          default: nib = CMD_OUT2_OFF;
        endcase
      end
    end
    push_request(op, {addr, nib});
  endtask

  initial begin
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    // Directed requests: empty table, unused operation, address extremes,
    // duplicate learn, every command nibble kind, miss, clear with outputs on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_request(OP_MATCH,  24'h000000);   // match on an empty table
    push_request(OP_UNUSED, 24'hFFFFFF);   // ignored operation
    push_request(OP_LEARN,  24'hFFFFF0);   // all-ones address
    push_request(OP_LEARN,  24'h000001);   // all-zeros address
    push_request(OP_LEARN,  24'h123450);
    push_request(OP_LEARN,  24'hFFFFF7);   // same address again, new entry
    push_request(OP_MATCH,  {20'hFFFFF, CMD_OUT1_ON});   // hits the first copy
    push_request(OP_MATCH,  {20'h00000, CMD_OUT2_ON});
    push_request(OP_MATCH,  {20'h12345, CMD_OUT1_OFF});
    push_request(OP_MATCH,  {20'hFFFFF, CMD_OUT2_OFF});
    push_request(OP_MATCH,  24'h12345F);   // other nibble leaves outputs alone
    push_request(OP_MATCH,  24'h000000);
    push_request(OP_MATCH,  {20'hFEDCB, CMD_OUT1_ON});   // miss keeps outputs
    push_request(OP_MATCH,  {20'h12345, CMD_OUT1_ON});
    push_request(OP_MATCH,  {20'h00000, CMD_OUT2_ON});
    push_request(OP_CLEAR,  24'hA5A5A5);   // outputs survive the clear
    push_request(OP_MATCH,  24'h000001);   // cleared table holds no live entry
    push_request(OP_CLEAR,  24'h000000);   // clear of an empty table
    push_request(OP_UNUSED, 24'h000000);
    push_request(OP_LEARN,  24'h5A5A5A);
    push_request(OP_MATCH,  {20'h5A5A5, CMD_OUT1_OFF});

    // Random phases: slow receiver, then slow sender while filling the table
    // to the top, then full rate on both sides.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 19 : 0;
      clear_base    = (phase == 0) ? 3 : 1;
      fill_mode     = (phase == 1);
      fill_goal     = sb.full_hits + 6;
      repeat (PHASE_REQUESTS) random_request();
    end
    in_tvalid <= 1'b0;

    // Drain: let the monitor log the last request, wait for every result,
    // then watch a full search time longer for anything stray.
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d requests: %0d hits, %0d misses, %0d learns, %0d table-full,",
             requests_sent, sb.status_tally[ST_MATCHED], sb.status_tally[ST_NOMATCH],
             sb.status_tally[ST_LEARNED], sb.status_tally[ST_FULL]);
    $display("%0d clears, peak fill %0d of %0d entries.",
             sb.status_tally[ST_CLEARED], sb.peak_fill, TABLE_DEPTH);
    if (sb.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Stop a hung run: far beyond the slowest correct run of these requests.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> learned_remote_code_matcher.f
rtl/lrcm_pkg.sv
rtl/lrcm_table.sv
rtl/lrcm_ctrl.sv
rtl/learned_remote_code_matcher.sv
dv/testbench.sv
